>>> src/irpde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpde_pkg
// Types, segment indexes and register codes shared by the encoder modules.
// ----------------------------------------------------------------------------
package irpde_pkg;

	localparam int unsigned DUR_W     = 16;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SEG_IDX_W = 5;
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
	localparam int unsigned REG_IDX_W = 3;

	typedef logic [DUR_W-1:0]     dur_t;
	typedef logic [SEG_IDX_W-1:0] seg_idx_t;

	// Position of a segment within the longest run a byte can produce
	localparam seg_idx_t SEG_HDR_MARK_ONE  = 5'd0;
	localparam seg_idx_t SEG_HDR_SPACE_ONE = 5'd1;
	localparam seg_idx_t SEG_HDR_MARK_TWO  = 5'd2;
	localparam seg_idx_t SEG_HDR_SPACE_TWO = 5'd3;
	localparam seg_idx_t SEG_BIT_FIRST     = 5'd4;
	localparam seg_idx_t SEG_BIT_LAST      = 5'd19;
	localparam seg_idx_t SEG_CLOSE         = 5'd20;

	// Configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_HDR_MARK_ONE  = 3'd0,
		REG_HDR_SPACE_ONE = 3'd1,
		REG_HDR_MARK_TWO  = 3'd2,
		REG_HDR_SPACE_TWO = 3'd3,
		REG_BIT_MARK      = 3'd4,
		REG_ONE_SPACE     = 3'd5,
		REG_ZERO_SPACE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		dur_t header_mark_one_us;
		dur_t header_space_one_us;
		dur_t header_mark_two_us;
		dur_t header_space_two_us;
		dur_t bit_mark_us;
		dur_t one_space_us;
		dur_t zero_space_us;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		header_mark_one_us:  16'd30000,
		header_space_one_us: 16'd49500,
		header_mark_two_us:  16'd3380,
		header_space_two_us: 16'd1700,
		bit_mark_us:         16'd410,
		one_space_us:        16'd1256,
		zero_space_us:       16'd422
	};

	// Classified byte request: payload plus the segment span to play
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		seg_idx_t          start_idx;
		seg_idx_t          end_idx;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} desc_chan_t;

	typedef struct packed {
		logic carrier_on;
		dur_t duration_us;
		logic frame_done;
		logic run_last;
	} seg_t;

endpackage

>>> src/irpde_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpde channel interfaces
// Valid/ready channels for command bytes in and mark/space segments out.
// ----------------------------------------------------------------------------
interface irpde_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface irpde_seg_if;
	logic        valid;
	logic        ready;
	logic        carrier_on;
	logic [15:0] duration_us;
	logic        frame_done;
	logic        run_last;

	modport source (output valid, carrier_on, duration_us, frame_done, run_last,
		input ready);
	modport sink   (input valid, carrier_on, duration_us, frame_done, run_last,
		output ready);
endinterface

>>> src/irpde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpde_front
// Accepts byte requests and classifies each into the span of segments to play.
// ----------------------------------------------------------------------------
module irpde_front import irpde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	irpde_byte_if.sink        byte_in,
	output desc_chan_t        push,
	input  logic              push_ready
);

	logic  valid_s1;
	desc_t desc_s1;
	logic  take;

	assign byte_in.ready = !valid_s1 || push_ready;
	assign take          = byte_in.valid && byte_in.ready;

	// Hold the request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify: header opens the span of a first byte, closing mark ends that of a last byte
	always_ff @(posedge clk) begin
		if (take) begin
			desc_s1.data_byte <= byte_in.data_byte;
			desc_s1.start_idx <= byte_in.first_byte ? SEG_HDR_MARK_ONE : SEG_BIT_FIRST;
			desc_s1.end_idx   <= byte_in.last_byte ? SEG_CLOSE : SEG_BIT_LAST;
		end
	end

	assign push.valid = valid_s1;
	assign push.desc  = desc_s1;

endmodule

>>> src/irpde_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpde_queue
// Short request queue between the classifying front and the segment sequencer.
// ----------------------------------------------------------------------------
module irpde_queue import irpde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  desc_chan_t  push,
	output logic        push_ready,
	output desc_chan_t  pop,
	input  logic        pop_ready
);

	desc_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.desc   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.desc;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue occupancy beyond depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue occupancy not raised on push");
`endif

endmodule

>>> src/irpde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpde_back
// Steps through the segment span of each request, one segment per cycle
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module irpde_back import irpde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  desc_chan_t  pop,
	output logic        pop_ready,
	irpde_seg_if.source seg_out
);

	logic              active_q;
	logic [BYTE_W-1:0] data_q;
	seg_idx_t          idx_q;
	seg_idx_t          end_idx_q;
	logic              out_valid_q;
	seg_t              out_q;
	logic              adv;
	logic              seg_last;
	logic              load;
	logic [3:0]        bit_off;
	logic [2:0]        bit_pos;
	seg_t              seg;

	assign adv       = !out_valid_q || seg_out.ready;
	assign seg_last  = (idx_q == end_idx_q);
	assign pop_ready = !active_q || (adv && seg_last);
	assign load      = pop.valid && pop_ready;

	// Decode the current segment index
	assign bit_off = idx_q[4:1] - 4'd2;
	assign bit_pos = bit_off[2:0];

	always_comb begin
		seg.frame_done = 1'b0;
		seg.run_last   = seg_last;
		unique case (idx_q)
			SEG_HDR_MARK_ONE: begin
				seg.carrier_on  = 1'b1;
				seg.duration_us = cfg.header_mark_one_us;
			end
			SEG_HDR_SPACE_ONE: begin
				seg.carrier_on  = 1'b0;
				seg.duration_us = cfg.header_space_one_us;
			end
			SEG_HDR_MARK_TWO: begin
				seg.carrier_on  = 1'b1;
				seg.duration_us = cfg.header_mark_two_us;
			end
			SEG_HDR_SPACE_TWO: begin
				seg.carrier_on  = 1'b0;
				seg.duration_us = cfg.header_space_two_us;
			end
			SEG_CLOSE: begin
				seg.carrier_on  = 1'b1;
				seg.duration_us = cfg.bit_mark_us;
				seg.frame_done  = 1'b1;
			end
			default: begin
				// Bit cells: mark on even index, coded space on odd
				seg.carrier_on = !idx_q[0];
				if (!idx_q[0]) begin
					seg.duration_us = cfg.bit_mark_us;
				end else if (data_q[bit_pos]) begin
					seg.duration_us = cfg.one_space_us;
				end else begin
					seg.duration_us = cfg.zero_space_us;
				end
			end
		endcase
	end

	// Sequence through the span; pick up the next request on the last segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= active_q;
			end
			if (load) begin
				active_q <= 1'b1;
			end else if (active_q && adv && seg_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q    <= pop.desc.data_byte;
			idx_q     <= pop.desc.start_idx;
			end_idx_q <= pop.desc.end_idx;
		end else if (active_q && adv) begin
			idx_q <= idx_q + 1'b1;
		end
		if (adv && active_q) begin
			out_q <= seg;
		end
	end

	assign seg_out.valid       = out_valid_q;
	assign seg_out.carrier_on  = out_q.carrier_on;
	assign seg_out.duration_us = out_q.duration_us;
	assign seg_out.frame_done  = out_q.frame_done;
	assign seg_out.run_last    = out_q.run_last;

`ifndef SYNTHESIS
	a_idx_span: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= end_idx_q))
		else $error("segment index past end of span");
	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_done) |-> (out_q.carrier_on && out_q.run_last))
		else $error("closing mark not a final carrier segment");
	a_no_load_midrun: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !seg_last) |-> !load)
		else $error("request loaded while a span is in progress");
`endif

endmodule

>>> src/ir_pulse_distance_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder
// Expands command bytes into pulse-distance coded mark/space segments.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one request per command byte (data_byte, first_byte,
//   last_byte). seg_out delivers one segment per transfer: carrier_on,
//   duration_us, frame_done on the closing mark, run_last on the final
//   segment of each byte.
//   A byte gives 16 segments (a mark and a coded space per bit, LSB first),
//   4 more header segments when first_byte is set and one closing mark when
//   last_byte is set: 16 to 21 segments.
//   The sequencer emits one segment per cycle while seg_out.ready allows, and
//   consecutive bytes follow with no gap. The first segment of a byte passes
//   through the input register, the queue and the sequencer's index register
//   before it reaches the output register.
//   Two requests wait in a queue ahead of the sequencer and one more in the
//   input register, so byte_in keeps accepting during an output stall until those are full.
//   When seg_out.ready is low the held segment stays put and the sequencer
//   waits; nothing is dropped.
//   Reset empties the queue and restores the default timings. The timing
//   registers are written through cfg_we/cfg_index/cfg_wdata, by the user only
//   while idle (the block does not enforce it); writes to an unused index are ignored.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder import irpde_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_wdata,
	irpde_byte_if.sink           byte_in,
	irpde_seg_if.source          seg_out
);

	cfg_t       cfg_q;
	desc_chan_t push;
	logic       push_ready;
	desc_chan_t pop;
	logic       pop_ready;

	// Timing register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HDR_MARK_ONE:  cfg_q.header_mark_one_us  <= cfg_wdata;
				REG_HDR_SPACE_ONE: cfg_q.header_space_one_us <= cfg_wdata;
				REG_HDR_MARK_TWO:  cfg_q.header_mark_two_us  <= cfg_wdata;
				REG_HDR_SPACE_TWO: cfg_q.header_space_two_us <= cfg_wdata;
				REG_BIT_MARK:      cfg_q.bit_mark_us         <= cfg_wdata;
				REG_ONE_SPACE:     cfg_q.one_space_us        <= cfg_wdata;
				REG_ZERO_SPACE:    cfg_q.zero_space_us       <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	irpde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.push       (push),
		.push_ready (push_ready)
	);

	irpde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	irpde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop       (pop),
		.pop_ready (pop_ready),
		.seg_out   (seg_out)
	);

endmodule
